>>> hdl/cov_pkg.sv
`timescale 1ns / 1ps
package cov_pkg;
  localparam int MaxFeatures = 8;
  localparam int MaxRows     = 256;
  localparam int FeatW       = 3;
  localparam int RowW        = 9;
  localparam int AddrW       = 11;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFewRows  = 2'd1;
  localparam logic [1:0] StatusPartial  = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               final_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         row_feature;
    logic [2:0]         col_feature;
    logic signed [63:0] covariance;
    logic [1:0]         status;
    logic               last_result;
  } out_item_t;
endpackage

>>> hdl/cov_in_if.sv
`timescale 1ns / 1ps
interface cov_in_if;
  logic              valid;
  logic              ready;
  cov_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/cov_out_if.sv
`timescale 1ns / 1ps
interface cov_out_if;
  logic               valid;
  logic               ready;
  cov_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/cov_divider.sv
`timescale 1ns / 1ps
module cov_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  dividend_i,
  input  logic [8:0]          divisor_i,
  output logic                done_o,
  output logic signed [63:0]  quotient_o
);
  logic [63:0] mag_q, mag_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  div_q;
  logic        neg_q, busy_q, busy_d, done_q;
  logic [6:0]  cnt_q, cnt_d;
  logic [9:0]  trial;

  assign trial = {rem_q, mag_q[63]};

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 9'(trial - {1'b0, div_q});
        mag_d = {mag_q[62:0], 1'b1};
      end else begin
        rem_d = trial[8:0];
        mag_d = {mag_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !busy_d;
      busy_q <= start_i ? 1'b1 : busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      neg_q <= dividend_i[63];
      div_q <= divisor_i;
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      mag_q <= mag_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? 64'(-mag_q) : mag_q;
endmodule

>>> hdl/covariance_matrix.sv
`timescale 1ns / 1ps
// channel  | dir | payload
// in_s     | in  | sample, final_sample
// out_m    | out | row_feature, col_feature, covariance, status, last_result
// cfg      | in  | num_features (write enable, data)
// a non-final item is stored; the final item triggers the computation (a status-only
// result if rows are too few, partial or overflowed): a mean pass per feature, then per
// entry a pair pass and a serial divide, all through one store read port and one multiplier
// reset clears control state; the store is not cleared
// a result waits in the output register until taken; no item is taken meanwhile
module covariance_matrix (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  cov_in_if.sink     in_s,
  cov_out_if.source  out_m
);
  import cov_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StMAcc  = 8'b00000010,
    StMDiv  = 8'b00000100,
    StPAcc  = 8'b00001000,
    StPTail = 8'b00010000,
    StPDiv  = 8'b00100000,
    StOut   = 8'b01000000,
    StDrain = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] store_mem [2**AddrW];
  logic signed [15:0] rd_q;
  logic [AddrW-1:0]   rd_addr;
  logic               rd_en;

  logic signed [24:0] mean_mem [MaxFeatures];

  logic [3:0]  nf_q;
  logic [2:0]  nf_m1;
  logic [2:0]  fpos_q;
  logic [RowW-1:0] rows_q;
  logic        ovf_q;

  logic [2:0]  fi_q, fj_q;
  logic        phase_q;
  logic [RowW-1:0] k_q;
  logic        rv_q;
  logic signed [63:0] acc_q;
  logic signed [24:0] a_q;
  logic signed [49:0] prod_w;
  logic signed [63:0] prod_q;
  logic        pv_q;
  logic        tail_q;

  logic        div_start;
  logic signed [63:0] div_in;
  logic [RowW-1:0] div_by;
  logic        div_done;
  logic signed [63:0] div_out;

  out_item_t   out_q;
  logic        out_v_q;

  logic        accept;
  logic        fin_row;
  logic [RowW-1:0] rows_new;
  logic [2:0]  fpos_new;
  logic        ovf_new;

  assign nf_m1 = (nf_q == 4'd0) ? 3'd0 : (nf_q > 4'd8) ? 3'd7 : 3'(nf_q - 4'd1);
  assign in_s.ready = (state_q == StIdle) && !out_v_q;
  assign accept = in_s.valid && in_s.ready;
  assign fin_row = (fpos_q == nf_m1) || (fpos_q > nf_m1);

  always_comb begin
    rows_new = rows_q;
    fpos_new = fpos_q;
    ovf_new  = ovf_q;
    if (rows_q >= RowW'(MaxRows)) ovf_new = 1'b1;
    else if (fin_row) begin
      fpos_new = '0;
      rows_new = rows_q + 1'b1;
    end else fpos_new = fpos_q + 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (accept && rows_q < RowW'(MaxRows))
      store_mem[{rows_q[7:0], fpos_q}] <= in_s.payload.sample;
    if (rd_en) rd_q <= store_mem[rd_addr];
  end

  // read pattern: mean pass on column fj, pair pass alternates fi and fj
  assign rd_en   = (state_q == StMAcc) || (state_q == StPAcc);
  assign rd_addr = {k_q[7:0], (state_q == StPAcc && !phase_q) ? fi_q : fj_q};

  logic signed [24:0] cen;
  assign cen = 25'($signed({rd_q, 8'd0})) - mean_mem[phase_q ? fi_q : fj_q];
  assign prod_w = 50'(a_q) * 50'(cen);

  assign div_in = (state_q == StMAcc) ? 64'($signed({acc_q, 8'd0})) : acc_q;
  assign div_by = (state_q == StMAcc) ? rows_q : rows_q - 1'b1;
  assign div_start = ((state_q == StMAcc) || (state_q == StPTail)) && tail_q && !pv_q
                     && !rv_q;

  cov_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_in),
    .divisor_i(div_by), .done_o(div_done), .quotient_o(div_out)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && in_s.payload.final_sample && !ovf_new && fpos_new == '0
            && rows_new >= 9'd2) state_d = StMAcc;
      end
      StMAcc:  if (div_start) state_d = StMDiv;
      StMDiv:  if (div_done) state_d = (fj_q == nf_m1) ? StPAcc : StMAcc;
      StPAcc:  if (k_q == rows_q - 1'b1 && phase_q) state_d = StPTail;
      StPTail: if (div_start) state_d = StPDiv;
      StPDiv:  if (div_done) state_d = StOut;
      StOut:   if (!out_v_q) state_d = StDrain;
      StDrain: state_d = (fj_q == nf_m1 && fi_q == nf_m1) ? StIdle : StPAcc;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nf_q    <= 4'd8;
      fpos_q  <= '0;
      rows_q  <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      tail_q  <= 1'b0;
      fi_q    <= '0;
      fj_q    <= '0;
      k_q     <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) nf_q <= cfg_wdata_i;
      if (out_v_q && out_m.ready) out_v_q <= 1'b0;
      rv_q <= rd_en && !(state_q == StMAcc && tail_q);
      pv_q <= rv_q && !phase_q && (state_q == StPAcc || state_q == StPTail);
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (in_s.payload.final_sample && state_d != StMAcc) begin
              out_v_q <= 1'b1;
              fpos_q <= '0; rows_q <= '0; ovf_q <= 1'b0;
            end else begin
              fpos_q <= fpos_new;
              rows_q <= rows_new;
              ovf_q  <= ovf_new;
            end
            if (in_s.payload.final_sample) begin
              fi_q <= '0; fj_q <= '0; k_q <= '0; phase_q <= 1'b0; tail_q <= 1'b0;
            end
          end
        end
        StMAcc: begin
          if (!tail_q) begin
            if (k_q == rows_q - 1'b1) tail_q <= 1'b1;
            else k_q <= k_q + 1'b1;
          end
        end
        StMDiv: begin
          if (div_done) begin
            k_q <= '0; tail_q <= 1'b0;
            if (fj_q != nf_m1) fj_q <= fj_q + 3'd1;
            else fj_q <= '0;
          end
        end
        StPAcc: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (k_q == rows_q - 1'b1) tail_q <= 1'b1;
            else k_q <= k_q + 1'b1;
          end
        end
        StPTail: begin
          phase_q <= 1'b0;
        end
        StPDiv: ;
        StOut: begin
          if (!out_v_q) out_v_q <= 1'b1;
        end
        StDrain: begin
          k_q <= '0; tail_q <= 1'b0; phase_q <= 1'b0;
          if (fj_q == nf_m1) begin
            fj_q <= '0;
            if (fi_q == nf_m1) begin
              fpos_q <= '0; rows_q <= '0; ovf_q <= 1'b0;
            end else fi_q <= fi_q + 3'd1;
          end else fj_q <= fj_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath: centred value a, then product, then accumulate; the mean pass accumulates raw samples
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle || state_q == StMDiv || state_q == StDrain) acc_q <= '0;
    else if (state_q == StMAcc && rv_q) acc_q <= acc_q + 64'(rd_q);
    else if (pv_q) acc_q <= acc_q + prod_q;
    if (state_q == StMDiv && div_done) mean_mem[fj_q] <= 25'(div_out);
    if (rv_q && (state_q == StPAcc || state_q == StPTail)) begin
      if (phase_q) a_q <= cen;
      else prod_q <= 64'(prod_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && accept && in_s.payload.final_sample && state_d != StMAcc) begin
      out_q.row_feature <= '0;
      out_q.col_feature <= '0;
      out_q.covariance  <= '0;
      out_q.last_result <= 1'b1;
      out_q.status <= ovf_new ? StatusOverflow :
                      (fpos_new != '0) ? StatusPartial : StatusFewRows;
    end else if (state_q == StOut && !out_v_q) begin
      out_q.row_feature <= fi_q;
      out_q.col_feature <= fj_q;
      out_q.covariance  <= div_out;
      out_q.status      <= StatusOk;
      out_q.last_result <= (fi_q == nf_m1) && (fj_q == nf_m1);
    end
  end

  assign out_m.valid   = out_v_q;
  assign out_m.payload = out_q;
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cov_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct {
    logic signed [15:0] sample;
    logic               final_sample;
    bit                 typed;
    logic [1:0]         status;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  cov_in_if  in_s ();
  cov_out_if out_m ();

  covariance_matrix i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (in_s.sink),
    .out_m       (out_m.source)
  );

  // predictor state
  logic signed [15:0] sample_mem [MaxRows*MaxFeatures];
  logic [3:0]         feat_count;
  int                 feat_pos;
  int                 row_total;
  bit                 rows_overflowed;
  out_item_t          fresh_entries [$];
  out_item_t          cov_expected [$];

  int  cyc = 0;
  int  bad_count = 0;
  bit  calm = 1'b0;

  plan_row_t plan [] = '{
    '{16'sh7fff, 1'b0, 1'b0, StatusOk},
    '{16'sh8000, 1'b0, 1'b0, StatusOk},
    '{16'sh8000, 1'b0, 1'b0, StatusOk},
    '{16'sh7fff, 1'b1, 1'b0, StatusOk},
    '{16'sh0000, 1'b0, 1'b0, StatusOk},
    '{16'sh0000, 1'b1, 1'b1, StatusFewRows},
    '{16'sh0001, 1'b0, 1'b0, StatusOk},
    '{16'shffff, 1'b0, 1'b0, StatusOk},
    '{16'sh0100, 1'b1, 1'b1, StatusPartial},
    '{16'sh8000, 1'b0, 1'b0, StatusOk},
    '{16'sh8000, 1'b0, 1'b0, StatusOk},
    '{16'sh8000, 1'b0, 1'b0, StatusOk},
    '{16'sh8000, 1'b1, 1'b0, StatusOk},
    '{16'sh0000, 1'b0, 1'b0, StatusOk},
    '{16'sh0001, 1'b0, 1'b0, StatusOk},
    '{16'sh0002, 1'b0, 1'b0, StatusOk},
    '{16'sh0003, 1'b0, 1'b0, StatusOk},
    '{16'shffff, 1'b0, 1'b0, StatusOk},
    '{16'shfffe, 1'b1, 1'b0, StatusOk}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    calm <= (cyc >= 4000 && cyc < 9000);
    if (cyc > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic model_sample(input logic signed [15:0] s, input logic f);
    int        nf;
    int        i;
    int        j;
    int        k;
    longint    sum;
    longint    a;
    longint    b;
    longint    acc;
    longint    mean [MaxFeatures];
    logic [1:0] code;
    out_item_t entry;
    begin
      nf = (feat_count == 0) ? 1 : (feat_count > MaxFeatures) ? MaxFeatures : feat_count;
      fresh_entries.delete();
      if (feat_pos >= MaxFeatures) feat_pos = 0;
      if (row_total >= MaxRows) begin
        rows_overflowed = 1'b1;
      end else begin
        sample_mem[row_total*MaxFeatures + feat_pos] = s;
        if (feat_pos + 1 >= nf) begin
          feat_pos = 0;
          row_total++;
        end else begin
          feat_pos++;
        end
      end
      if (!f) return;
      if (rows_overflowed) code = StatusOverflow;
      else if (feat_pos != 0) code = StatusPartial;
      else if (row_total < 2) code = StatusFewRows;
      else code = StatusOk;
      if (code != StatusOk) begin
        entry = '0;
        entry.status = code;
        entry.last_result = 1'b1;
        fresh_entries.insert(fresh_entries.size(), entry);
      end else begin
        for (j = 0; j < nf; j++) begin
          sum = 0;
          for (k = 0; k < row_total; k++) sum += sample_mem[k*MaxFeatures + j];
          mean[j] = (sum * 256) / longint'(row_total);
        end
        for (i = 0; i < nf; i++) begin
          for (j = 0; j < nf; j++) begin
            acc = 0;
            for (k = 0; k < row_total; k++) begin
              a = longint'(sample_mem[k*MaxFeatures + i]) * 256 - mean[i];
              b = longint'(sample_mem[k*MaxFeatures + j]) * 256 - mean[j];
              acc += a * b;
            end
            entry.row_feature = i[2:0];
            entry.col_feature = j[2:0];
            entry.covariance  = acc / longint'(row_total - 1);
            entry.status      = StatusOk;
            entry.last_result = (i == nf - 1 && j == nf - 1);
            fresh_entries.insert(fresh_entries.size(), entry);
          end
        end
      end
      feat_pos = 0;
      row_total = 0;
      rows_overflowed = 1'b0;
    end
  endtask

  task automatic send_item(input logic signed [15:0] s, input logic f);
    begin
      if (!calm && $urandom_range(0, 99) < 22) begin
        in_s.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_s.valid   <= 1'b1;
      in_s.payload <= '{sample: s, final_sample: f};
      do @(posedge clk_i); while (!in_s.ready);
      model_sample(s, f);
    end
  endtask

  task automatic write_features(input logic [3:0] v);
    begin
      in_s.valid <= 1'b0;
      while (cov_expected.size() != 0) @(posedge clk_i);
      repeat (20) @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= v;
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      feat_count = v;
    end
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker, ready drawn per cycle
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_m.valid && out_m.ready) begin
      got = out_m.payload;
      if (cov_expected.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = cov_expected.pop_front();
        if (got.row_feature !== want.row_feature || got.col_feature !== want.col_feature ||
            got.covariance !== want.covariance || got.status !== want.status ||
            got.last_result !== want.last_result) begin
          bad_count++;
          if (bad_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    out_m.ready <= calm || ($urandom_range(0, 99) >= 22);
  end

  initial begin
    int        r;
    int        n;
    int        rows;
    int        nf;
    logic [3:0] v;
    plan_row_t row;
    out_item_t entry;
    in_s.valid   = 1'b0;
    in_s.payload = '0;
    feat_count = 4'd8;
    feat_pos = 0;
    row_total = 0;
    rows_overflowed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, two features per row
    write_features(4'd2);
    foreach (plan[p]) begin
      row = plan[p];
      send_item(row.sample, row.final_sample);
      if (row.typed) begin
        entry = '0;
        entry.status = row.status;
        entry.last_result = 1'b1;
        cov_expected.insert(cov_expected.size(), entry);
      end else begin
        foreach (fresh_entries[q]) cov_expected.insert(cov_expected.size(), fresh_entries[q]);
      end
    end

    // random data sets
    for (r = 0; r < 13; r++) begin
      case (r)
        0: v = 4'd0;
        1: v = 4'd15;
        2: v = 4'd1;
        3: v = 4'd8;
        default: v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(1, 8));
      endcase
      write_features(v);
      nf = (v == 0) ? 1 : (v > 8) ? 8 : v;
      rows = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 5);
      n = rows * nf;
      if (nf > 1 && $urandom_range(0, 9) == 0) n = n - $urandom_range(1, nf - 1);
      for (int t = 0; t < n; t++) send_item(pick_sample(), t == n - 1);
      foreach (fresh_entries[q]) cov_expected.insert(cov_expected.size(), fresh_entries[q]);
    end

    in_s.valid <= 1'b0;
    while (cov_expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
